>>> rtl/clist_pkg.sv
// Shared constants, types and a helper function for the circular list block.
package clist_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int ST_W       = 2;
    localparam int OCC_W      = 5;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [ST_W-1:0]   t_status;

    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_BACK  = 3'd1;
    localparam t_cmd CMD_LIST      = 3'd2;
    localparam t_cmd CMD_REMOVE    = 3'd3;
    localparam t_cmd CMD_CLEAR     = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic    latch;
        logic    insert;
        logic    clear;
        logic    start;
        logic    list_step;
        logic    rem_step;
        logic    resp;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic last;
        logic removed_zero;
        logic out_free;
    } t_dp_stat;

    function automatic t_idx slot_of(input t_idx front, input t_idx off);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (IDX_W+1)'(LIST_DEPTH)) begin
            sum = sum - (IDX_W+1)'(LIST_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/clist_ctrl.sv
// Command sequencer for the circular list block.
module clist_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  clist_pkg::t_dp_stat i_stat,
    output clist_pkg::t_dp_cmd  o_ctl,
    output logic                o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_WALK_L = 3'd2;
    localparam logic [2:0] S_WALK_R = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]         r_state, n_state;
    clist_pkg::t_status r_resp_st, n_resp_st;
    logic               r_rem, n_rem;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_resp_st = r_resp_st;
        n_rem     = r_rem;
        o_ctl     = '0;
        o_ctl.status = (r_rem && i_stat.removed_zero) ? clist_pkg::ST_NOT_FOUND : r_resp_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                n_rem = 1'b0;
                case (i_stat.cmd) inside
                    clist_pkg::CMD_INS_FRONT, clist_pkg::CMD_INS_BACK: begin
                        n_state = S_RESP;
                        if (i_stat.full) begin
                            n_resp_st = clist_pkg::ST_FULL;
                        end else begin
                            o_ctl.insert = 1'b1;
                            n_resp_st    = clist_pkg::ST_OK;
                        end
                    end
                    clist_pkg::CMD_LIST, clist_pkg::CMD_REMOVE, clist_pkg::CMD_CLEAR: begin
                        n_resp_st = clist_pkg::ST_OK;
                        if (i_stat.empty) begin
                            n_resp_st = clist_pkg::ST_EMPTY;
                            n_state   = S_RESP;
                        end else if (i_stat.cmd == clist_pkg::CMD_CLEAR) begin
                            o_ctl.clear = 1'b1;
                            n_state     = S_RESP;
                        end else if (i_stat.cmd == clist_pkg::CMD_LIST) begin
                            o_ctl.start = 1'b1;
                            n_state     = S_WALK_L;
                        end else begin
                            o_ctl.start = 1'b1;
                            n_rem       = 1'b1;
                            n_state     = S_WALK_R;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WALK_L: begin
                if (i_stat.out_free) begin
                    o_ctl.list_step = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK_R: begin
                o_ctl.rem_step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctl.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_resp_st <= clist_pkg::ST_OK;
            r_rem     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_resp_st <= n_resp_st;
            r_rem     <= n_rem;
        end
    end

endmodule

>>> rtl/clist_dp.sv
// Datapath of the circular list block: entry memory, pointers and result register.
module clist_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [clist_pkg::CMD_W-1:0]     i_command,
    input  logic signed [clist_pkg::DATA_W-1:0] i_value,
    input  clist_pkg::t_dp_cmd              i_ctl,
    input  logic                            i_stall,
    output clist_pkg::t_dp_stat             o_stat,
    output logic                            o_valid,
    output logic signed [clist_pkg::DATA_W-1:0] o_entry_value,
    output logic                            o_last_flag,
    output logic [clist_pkg::ST_W-1:0]      o_status,
    output logic [clist_pkg::OCC_W-1:0]     o_removed_count,
    output logic [clist_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int IDX_W = clist_pkg::IDX_W;
    localparam int CNT_W = clist_pkg::CNT_W;

    logic [clist_pkg::DATA_W-1:0] r_mem [clist_pkg::LIST_DEPTH];
    logic [clist_pkg::DATA_W-1:0] r_rdata;

    clist_pkg::t_cmd    r_cmd;
    logic [clist_pkg::DATA_W-1:0] r_val;
    clist_pkg::t_idx    r_front;
    clist_pkg::t_cnt    r_count;
    clist_pkg::t_idx    r_idx;
    clist_pkg::t_cnt    r_kept;
    clist_pkg::t_cnt    r_removed;

    logic                         r_ovalid;
    logic [clist_pkg::DATA_W-1:0] r_oval;
    logic                         r_olast;
    clist_pkg::t_status           r_ost;
    clist_pkg::t_cnt              r_orem;
    clist_pkg::t_cnt              r_oocc;

    logic                         is_last;
    logic                         match;
    logic                         step;
    logic                         out_free;
    clist_pkg::t_cnt              kept_next;
    clist_pkg::t_idx              front_dec;
    clist_pkg::t_idx              rd_off;
    clist_pkg::t_idx              rd_addr;
    logic                         we;
    clist_pkg::t_idx              waddr;
    logic [clist_pkg::DATA_W-1:0] wdata;

    assign is_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign match     = (r_rdata == r_val);
    assign step      = i_ctl.list_step | i_ctl.rem_step;
    assign out_free  = !r_ovalid || !i_stall;
    assign kept_next = match ? r_kept : r_kept + CNT_W'(1);
    assign front_dec = (r_front == '0) ? IDX_W'(clist_pkg::LIST_DEPTH - 1)
                                       : r_front - IDX_W'(1);
    assign rd_off    = i_ctl.start ? '0 : (step ? r_idx + IDX_W'(1) : r_idx);
    assign rd_addr   = clist_pkg::slot_of(r_front, rd_off);

    always_comb begin
        we    = 1'b0;
        waddr = clist_pkg::slot_of(r_front, r_kept[IDX_W-1:0]);
        wdata = r_rdata;
        if (i_ctl.insert) begin
            we    = 1'b1;
            wdata = r_val;
            if (r_cmd == clist_pkg::CMD_INS_FRONT) begin
                waddr = front_dec;
            end else begin
                waddr = clist_pkg::slot_of(r_front, r_count[IDX_W-1:0]);
            end
        end else if (i_ctl.rem_step && !match) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.insert) begin
                r_count <= r_count + CNT_W'(1);
                if (r_cmd == clist_pkg::CMD_INS_FRONT) begin
                    r_front <= front_dec;
                end
            end
            if (i_ctl.clear) begin
                r_count <= '0;
                r_front <= '0;
            end
            if (i_ctl.rem_step && is_last) begin
                r_count <= kept_next;
            end
            if (i_ctl.list_step || i_ctl.resp) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd     <= i_command;
            r_val     <= i_value;
            r_removed <= '0;
        end
        if (i_ctl.start) begin
            r_idx  <= '0;
            r_kept <= '0;
        end
        if (step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_ctl.rem_step) begin
            r_kept <= kept_next;
            if (is_last) begin
                r_removed <= r_count - kept_next;
            end
        end
        if (i_ctl.list_step) begin
            r_oval  <= r_rdata;
            r_olast <= is_last;
            r_ost   <= clist_pkg::ST_OK;
            r_orem  <= '0;
            r_oocc  <= r_count;
        end else if (i_ctl.resp) begin
            r_oval  <= '0;
            r_olast <= 1'b1;
            r_ost   <= i_ctl.status;
            r_orem  <= r_removed;
            r_oocc  <= r_count;
        end
    end

    assign o_stat.cmd          = r_cmd;
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.full         = (r_count >= CNT_W'(clist_pkg::LIST_DEPTH));
    assign o_stat.last         = is_last;
    assign o_stat.removed_zero = (r_removed == '0);
    assign o_stat.out_free     = out_free;

    assign o_valid         = r_ovalid;
    assign o_entry_value   = r_oval;
    assign o_last_flag     = r_olast;
    assign o_status        = r_ost;
    assign o_removed_count = clist_pkg::OCC_W'(r_orem);
    assign o_occupancy     = clist_pkg::OCC_W'(r_oocc);

endmodule

>>> rtl/circular_list_insert_remove_all_core.sv
// Insert and clear pass through the dispatch and response states before the result register is loaded.
// List gives one result per cycle while the output is not stalled; remove walks the list at one
// entry per cycle, bound by the memory port, and then loads its result.
// One item is worked on at a time; the next is accepted once the result register is loaded.
// Reset is synchronous and active low; it empties the list, entry memory is not cleared.
// Top level of the circular list block: sequencer and datapath.
module circular_list_insert_remove_all_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [clist_pkg::CMD_W-1:0]     i_command,
    input  logic signed [clist_pkg::DATA_W-1:0] i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [clist_pkg::DATA_W-1:0] o_entry_value,
    output logic                            o_last_flag,
    output logic [clist_pkg::ST_W-1:0]      o_status,
    output logic [clist_pkg::OCC_W-1:0]     o_removed_count,
    output logic [clist_pkg::OCC_W-1:0]     o_occupancy
);

    clist_pkg::t_dp_cmd  ctl;
    clist_pkg::t_dp_stat stat;
    logic                busy;

    assign o_stall = busy;

    clist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    clist_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_command),
        .i_value         (i_value),
        .i_ctl           (ctl),
        .i_stall         (i_stall),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_entry_value   (o_entry_value),
        .o_last_flag     (o_last_flag),
        .o_status        (o_status),
        .o_removed_count (o_removed_count),
        .o_occupancy     (o_occupancy)
    );

`ifndef ASSERT_OFF
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != clist_pkg::ST_OK |-> o_last_flag)
        else $error("non-ok result not marked last");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_removed_count != '0 |-> o_status == clist_pkg::ST_OK && o_last_flag)
        else $error("removal count on a wrong result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted item did not make the block busy");

    a_occupancy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_occupancy <= clist_pkg::LIST_DEPTH)
        else $error("occupancy beyond list depth");
`endif

endmodule

>>> tb/tb.sv
// Testbench for the circular list core: directed and random commands checked against a shadow list.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [clist_pkg::DATA_W-1:0] entry_value;
        logic                         last_flag;
        clist_pkg::t_status           status;
        logic [clist_pkg::OCC_W-1:0]  removed_count;
        logic [clist_pkg::OCC_W-1:0]  occupancy;
    } t_reply;

    class clist_shadow;
        logic [clist_pkg::DATA_W-1:0] slots [clist_pkg::LIST_DEPTH];
        int unsigned                  front;
        int unsigned                  held;
        t_reply                       awaited_replies [$];
        int unsigned                  errors;

        function new();
            front  = 0;
            held   = 0;
            errors = 0;
        endfunction

        function void queue_reply(logic [clist_pkg::DATA_W-1:0] value, logic last,
                                  clist_pkg::t_status status, int unsigned removed);
            t_reply r;
            r.entry_value   = value;
            r.last_flag     = last;
            r.status        = status;
            r.removed_count = (clist_pkg::OCC_W)'(removed);
            r.occupancy     = (clist_pkg::OCC_W)'(held);
            awaited_replies.push_back(r);
        endfunction

        function void note_command(clist_pkg::t_cmd cmd, logic [clist_pkg::DATA_W-1:0] value);
            int unsigned                  kept;
            int unsigned                  removed;
            logic [clist_pkg::DATA_W-1:0] e;
            if (cmd == clist_pkg::CMD_INS_FRONT || cmd == clist_pkg::CMD_INS_BACK) begin
                if (held >= clist_pkg::LIST_DEPTH) begin
                    queue_reply('0, 1'b1, clist_pkg::ST_FULL, 0);
                end else begin
                    if (cmd == clist_pkg::CMD_INS_FRONT) begin
                        front = (front + clist_pkg::LIST_DEPTH - 1) % clist_pkg::LIST_DEPTH;
                        slots[front] = value;
                    end else begin
                        slots[(front + held) % clist_pkg::LIST_DEPTH] = value;
                    end
                    held++;
                    queue_reply('0, 1'b1, clist_pkg::ST_OK, 0);
                end
            end else if (cmd == clist_pkg::CMD_LIST || cmd == clist_pkg::CMD_REMOVE ||
                         cmd == clist_pkg::CMD_CLEAR) begin
                if (held == 0) begin
                    queue_reply('0, 1'b1, clist_pkg::ST_EMPTY, 0);
                end else if (cmd == clist_pkg::CMD_LIST) begin
                    for (int i = 0; i < held; i++) begin
                        queue_reply(slots[(front + i) % clist_pkg::LIST_DEPTH], i == held - 1,
                                    clist_pkg::ST_OK, 0);
                    end
                end else if (cmd == clist_pkg::CMD_REMOVE) begin
                    kept = 0;
                    for (int i = 0; i < held; i++) begin
                        e = slots[(front + i) % clist_pkg::LIST_DEPTH];
                        if (e !== value) begin
                            slots[(front + kept) % clist_pkg::LIST_DEPTH] = e;
                            kept++;
                        end
                    end
                    removed = held - kept;
                    held    = kept;
                    queue_reply('0, 1'b1,
                                (removed == 0) ? clist_pkg::ST_NOT_FOUND : clist_pkg::ST_OK,
                                removed);
                end else begin
                    held  = 0;
                    front = 0;
                    queue_reply('0, 1'b1, clist_pkg::ST_OK, 0);
                end
            end
        endfunction

        function logic [clist_pkg::DATA_W-1:0] pick_held_value();
            if (held == 0) begin
                return $urandom;
            end
            return slots[(front + $urandom_range(0, held - 1)) % clist_pkg::LIST_DEPTH];
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                $error("unexpected result: entry_value %h status %0d", got.entry_value,
                       got.status);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            if (got.entry_value !== want.entry_value) begin
                $error("entry_value expected %h got %h", want.entry_value, got.entry_value);
                errors++;
            end
            if (got.last_flag !== want.last_flag) begin
                $error("last_flag expected %0d got %0d", want.last_flag, got.last_flag);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                errors++;
            end
            if (got.removed_count !== want.removed_count) begin
                $error("removed_count expected %0d got %0d", want.removed_count,
                       got.removed_count);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy expected %0d got %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    clist_pkg::t_cmd                     i_command;
    logic signed [clist_pkg::DATA_W-1:0] i_value;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [clist_pkg::DATA_W-1:0] o_entry_value;
    logic                                o_last_flag;
    logic [clist_pkg::ST_W-1:0]          o_status;
    logic [clist_pkg::OCC_W-1:0]         o_removed_count;
    logic [clist_pkg::OCC_W-1:0]         o_occupancy;

    clist_shadow shadow = new();
    bit          steady;
    int unsigned quiet_cycles = 0;

    circular_list_insert_remove_all_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_entry_value  (o_entry_value),
        .o_last_flag    (o_last_flag),
        .o_status       (o_status),
        .o_removed_count(o_removed_count),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input clist_pkg::t_cmd cmd,
                             input logic [clist_pkg::DATA_W-1:0] value);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        shadow.note_command(cmd, value);
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : drain
        int unsigned hold;
        t_reply      got;
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.entry_value   = o_entry_value;
            got.last_flag     = o_last_flag;
            got.status        = o_status;
            got.removed_count = o_removed_count;
            got.occupancy     = o_occupancy;
            shadow.check_result(got);
        end
    end

    initial begin : stimulus
        int unsigned                  r;
        int unsigned                  ins_lim;
        int unsigned                  list_lim;
        int unsigned                  rem_lim;
        int unsigned                  clr_lim;
        bit                           filling;
        clist_pkg::t_cmd              cmd;
        logic [clist_pkg::DATA_W-1:0] val;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_command <= clist_pkg::CMD_INS_FRONT;
        i_value   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Commands on an empty list, then the unnamed command codes.
        send_item(clist_pkg::CMD_LIST, '0);
        send_item(clist_pkg::CMD_REMOVE, 32'd5);
        send_item(clist_pkg::CMD_CLEAR, '0);
        for (int c = clist_pkg::CMD_CLEAR + 1; c < (1 << clist_pkg::CMD_W); c++) begin
            send_item(clist_pkg::t_cmd'(c), $urandom);
        end

        send_item(clist_pkg::CMD_INS_FRONT, 32'h8000_0000);
        send_item(clist_pkg::CMD_INS_BACK, 32'h7fff_ffff);
        send_item(clist_pkg::CMD_INS_FRONT, 32'h0000_0000);
        send_item(clist_pkg::CMD_INS_BACK, 32'hffff_ffff);
        send_item(clist_pkg::CMD_LIST, '0);
        send_item(clist_pkg::CMD_REMOVE, 32'h0000_0000);
        send_item(clist_pkg::CMD_REMOVE, 32'd12345);

        // Fill to capacity, then overflow from both ends.
        for (int i = 0; i < clist_pkg::LIST_DEPTH - 3; i++) begin
            send_item(i[0] ? clist_pkg::CMD_INS_BACK : clist_pkg::CMD_INS_FRONT, 32'd7);
        end
        send_item(clist_pkg::CMD_INS_FRONT, 32'd1);
        send_item(clist_pkg::CMD_INS_BACK, 32'd1);
        send_item(clist_pkg::CMD_LIST, '0);
        send_item(clist_pkg::CMD_REMOVE, 32'd7);

        // Remove the remaining entries one by one until the list is empty.
        send_item(clist_pkg::CMD_REMOVE, 32'h8000_0000);
        send_item(clist_pkg::CMD_REMOVE, 32'h7fff_ffff);
        send_item(clist_pkg::CMD_REMOVE, 32'hffff_ffff);
        send_item(clist_pkg::CMD_LIST, '0);
        send_item(clist_pkg::CMD_INS_BACK, 32'd3);
        send_item(clist_pkg::CMD_CLEAR, '0);

        filling = 1'b0;
        for (int n = 0; n < 300; n++) begin
            if (n % 40 == 0) begin
                filling = !filling;
                steady  = ($urandom_range(0, 2) == 0);
            end
            if (n == 150) begin
                i_valid <= 1'b0;
                while (shadow.awaited_replies.size() != 0) @(posedge i_clk);
            end
            ins_lim  = filling ? 60 : 25;
            list_lim = ins_lim + 15;
            rem_lim  = list_lim + (filling ? 20 : 45);
            clr_lim  = rem_lim + (filling ? 2 : 8);
            case ($urandom_range(0, 5))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7fff_ffff;
                2:       val = '1;
                default: val = $urandom_range(0, 3);
            endcase
            r = $urandom_range(0, 99);
            if (r < ins_lim) begin
                cmd = $urandom_range(0, 1) ? clist_pkg::CMD_INS_BACK : clist_pkg::CMD_INS_FRONT;
                if ($urandom_range(0, 9) >= 4) begin
                    val = $urandom;
                end
            end else if (r < list_lim) begin
                cmd = clist_pkg::CMD_LIST;
                val = $urandom;
            end else if (r < rem_lim) begin
                cmd = clist_pkg::CMD_REMOVE;
                if ($urandom_range(0, 3) != 0) begin
                    val = shadow.pick_held_value();
                end else if ($urandom_range(0, 1) != 0) begin
                    val = $urandom;
                end
            end else if (r < clr_lim) begin
                cmd = clist_pkg::CMD_CLEAR;
                val = $urandom;
            end else begin
                cmd = clist_pkg::t_cmd'($urandom_range(clist_pkg::CMD_CLEAR + 1,
                                                       (1 << clist_pkg::CMD_W) - 1));
                val = $urandom;
            end
            send_item(cmd, val);
        end

        i_valid <= 1'b0;
        steady = 1'b0;
        while (shadow.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (clist_pkg::LIST_DEPTH + 8) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
